// ===== rtl/sfg_pkg.sv =====
// ---------------------------------------------------------------------------
// sfg_pkg
// Shared types and constants for the spring force generator.
// ---------------------------------------------------------------------------
package sfg_pkg;

	localparam int unsigned MAG_W   = 33;  // |p - q| per axis
	localparam int unsigned RAD_W   = 66;  // dx^2 + dy^2
	localparam int unsigned ROOT_W  = 33;  // floor sqrt of the radicand
	localparam int unsigned REM_W   = 36;  // partial remainder of the root
	localparam int unsigned N_CELLS = 33;  // one root digit per cell
	localparam int unsigned IDX_W   = 2;

	localparam logic [IDX_W-1:0] CFG_MODE      = 2'd0;
	localparam logic [IDX_W-1:0] CFG_REST_LEN  = 2'd1;
	localparam logic [IDX_W-1:0] CFG_STIFFNESS = 2'd2;

	localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
	localparam logic [31:0] NEG_MIN = 32'h8000_0000;
	localparam logic [31:0] STIFF_RESET = 32'h0001_0000;

	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic             negx;
		logic             negy;
	} sfg_pay_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		sfg_pay_t          pay;
	} sfg_sq_t;

endpackage

// ===== rtl/sfg_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// sfg_sqrt_cell
// One digit of a restoring square root; hands the shifted radicand on.
// ---------------------------------------------------------------------------
module sfg_sqrt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_i,
	input  sfg_pkg::sfg_sq_t sq_i,
	output logic             vld_o,
	output sfg_pkg::sfg_sq_t sq_o
);

	logic [sfg_pkg::REM_W-1:0] rem_sh;
	logic [sfg_pkg::REM_W-1:0] trial;
	logic                      ge;
	sfg_pkg::sfg_sq_t          nxt;

	always_comb begin
		rem_sh   = {sq_i.rem[sfg_pkg::REM_W-3:0], sq_i.rad[sfg_pkg::RAD_W-1 -: 2]};
		trial    = {1'b0, sq_i.root, 2'b01};
		ge       = (rem_sh >= trial);
		nxt.rad  = {sq_i.rad[sfg_pkg::RAD_W-3:0], 2'b00};
		nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
		nxt.root = {sq_i.root[sfg_pkg::ROOT_W-2:0], ge};
		nxt.pay  = sq_i.pay;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_o <= nxt;
		end
	end

endmodule

// ===== rtl/sfg_scale.sv =====
// ---------------------------------------------------------------------------
// sfg_scale
// Turn length and offsets into the saturated Hooke force; last stage is the
// output register.
// ---------------------------------------------------------------------------
module sfg_scale #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_i,
	input  logic [sfg_pkg::ROOT_W-1:0]  len_i,
	input  sfg_pkg::sfg_pay_t           pay_i,
	input  logic                        mode,
	input  logic [31:0]                 rest_len,
	input  logic [31:0]                 stiffness,
	output logic                        vld_o,
	output logic [31:0]                 fx_o,
	output logic [31:0]                 fy_o,
	output logic                        applied_o,
	output logic                        sat_o
);

	localparam int TP_W = 65;
	localparam int TC_W = 33 + FRAC_BITS;
	localparam int HI_W = TC_W - 32;
	localparam int PL_W = 32 + sfg_pkg::MAG_W;
	localparam int PH_W = HI_W + sfg_pkg::MAG_W;
	localparam int PW   = 66 + FRAC_BITS;

	logic [33:0]               diff;
	logic                      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [32:0]               adiff_s1;
	logic                      dpos_s1, dneg_s1, slack_s1;
	sfg_pkg::sfg_pay_t         pay_s1;
	logic [TP_W-1:0]           tprod_s2;
	logic [TP_W-1:0]           tfull;
	logic [1:0]                fneg_s2, fneg_s3, fneg_s4, fneg_s5;
	logic                      slack_s2, slack_s3, slack_s4, slack_s5;
	logic [sfg_pkg::MAG_W-1:0] mag_s2 [2];
	logic [sfg_pkg::MAG_W-1:0] mag_s3 [2];
	logic [TC_W-1:0]           tc_s3;
	logic [PL_W-1:0]           pl_s4 [2];
	logic [PH_W-1:0]           ph_s4 [2];
	logic [PW-1:0]             prod_s5 [2];
	logic [65:0]               m [2];
	logic [31:0]               f [2];
	logic [1:0]                sat;

	assign diff = {1'b0, len_i} - {2'b00, rest_len};
	assign tfull = tprod_s2 >> FRAC_BITS;

	// Clamp t: anything at or past 2^(32+F) saturates any nonzero component.
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			m[c]   = prod_s5[c][FRAC_BITS +: 66];
			f[c]   = '0;
			sat[c] = 1'b0;
			if (!slack_s5 && m[c] != '0) begin
				if (fneg_s5[c]) begin
					if (|m[c][65:32] || (m[c][31] && |m[c][30:0])) begin
						f[c]   = sfg_pkg::NEG_MIN;
						sat[c] = 1'b1;
					end else begin
						f[c] = 32'd0 - m[c][31:0];
					end
				end else begin
					if (|m[c][65:31]) begin
						f[c]   = sfg_pkg::POS_MAX;
						sat[c] = 1'b1;
					end else begin
						f[c] = m[c][31:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_o  <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adiff_s1 <= diff[33] ? 33'(34'd0 - diff) : diff[32:0];
			dneg_s1  <= diff[33];
			dpos_s1  <= !diff[33] && (diff != '0);
			slack_s1 <= mode && !(len_i > {1'b0, rest_len});
			pay_s1   <= pay_i;

			tprod_s2   <= TP_W'(stiffness * adiff_s1);
			fneg_s2[0] <= (dpos_s1 && !pay_s1.negx && pay_s1.ax != '0) ||
			              (dneg_s1 && pay_s1.negx);
			fneg_s2[1] <= (dpos_s1 && !pay_s1.negy && pay_s1.ay != '0) ||
			              (dneg_s1 && pay_s1.negy);
			slack_s2   <= slack_s1;
			mag_s2[0]  <= pay_s1.ax;
			mag_s2[1]  <= pay_s1.ay;

			tc_s3     <= (tfull >= (TP_W'(1) << (32 + FRAC_BITS))) ?
			             (TC_W'(1) << (32 + FRAC_BITS)) : TC_W'(tfull);
			fneg_s3   <= fneg_s2;
			slack_s3  <= slack_s2;
			mag_s3    <= mag_s2;

			for (int c = 0; c < 2; c++) begin
				pl_s4[c]   <= PL_W'(tc_s3[31:0] * mag_s3[c]);
				ph_s4[c]   <= PH_W'(tc_s3[TC_W-1:32] * mag_s3[c]);
				prod_s5[c] <= PW'(pl_s4[c]) + (PW'(ph_s4[c]) << 32);
			end
			fneg_s4  <= fneg_s3;
			slack_s4 <= slack_s3;
			fneg_s5  <= fneg_s4;
			slack_s5 <= slack_s4;

			fx_o      <= f[0];
			fy_o      <= f[1];
			applied_o <= !slack_s5;
			sat_o     <= |sat;
		end
	end

endmodule

// ===== rtl/spring_force_generator.sv =====
// ---------------------------------------------------------------------------
// spring_force_generator
// Hooke spring force F = -k * (|d| - L) * d on a particle, d = p - q.
// ---------------------------------------------------------------------------
// Takes one beat per clock while not stalled and returns one result beat
// per input beat, in order: front stages form the offsets, their squares
// and the sum, a row of 33 square-root cells resolves one root bit each,
// and the scale stages scale by stiffness and the offsets and saturate. The
// whole pipe advances together and only holds while a finished result waits
// on out_ready. Positions are signed fixed point with FRAC_BITS fraction
// bits; write configuration only while no beat is in flight.
module spring_force_generator #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] particle_x,
	input  logic [31:0] particle_y,
	input  logic [31:0] endpoint_x,
	input  logic [31:0] endpoint_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] force_x,
	output logic [31:0] force_y,
	output logic        force_applied,
	output logic        saturated
);

	logic              spring_mode_q;
	logic [31:0]       rest_length_q;
	logic [31:0]       spring_stiffness_q;
	logic              en;
	logic [32:0]       dx, dy;
	logic              vld_s1, vld_s2, vld_s3;
	sfg_pkg::sfg_pay_t pay_s1, pay_s2, pay_s3;
	logic [sfg_pkg::RAD_W-1:0] sqx_s2, sqy_s2, rad_s3;
	logic              cvld [sfg_pkg::N_CELLS+1];
	sfg_pkg::sfg_sq_t  csq  [sfg_pkg::N_CELLS+1];

	// Advance everything unless the output register is full and stalled.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_mode_q      <= 1'b0;
			rest_length_q      <= '0;
			spring_stiffness_q <= sfg_pkg::STIFF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfg_pkg::CFG_MODE:      spring_mode_q      <= cfg_data[0];
				sfg_pkg::CFG_REST_LEN:  rest_length_q      <= cfg_data;
				sfg_pkg::CFG_STIFFNESS: spring_stiffness_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Exact 33-bit offsets; magnitudes fit 33 bits unsigned.
	assign dx = {particle_x[31], particle_x} - {endpoint_x[31], endpoint_x};
	assign dy = {particle_y[31], particle_y} - {endpoint_y[31], endpoint_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1.ax   <= dx[32] ? (33'd0 - dx) : dx;
			pay_s1.ay   <= dy[32] ? (33'd0 - dy) : dy;
			pay_s1.negx <= dx[32];
			pay_s1.negy <= dy[32];
			sqx_s2      <= sfg_pkg::RAD_W'(pay_s1.ax * pay_s1.ax);
			sqy_s2      <= sfg_pkg::RAD_W'(pay_s1.ay * pay_s1.ay);
			pay_s2      <= pay_s1;
			rad_s3      <= sqx_s2 + sqy_s2;
			pay_s3      <= pay_s2;
		end
	end

	// Feed the root row with a clear remainder and root.
	assign cvld[0]     = vld_s3;
	assign csq[0].rad  = rad_s3;
	assign csq[0].rem  = '0;
	assign csq[0].root = '0;
	assign csq[0].pay  = pay_s3;

	for (genvar i = 0; i < sfg_pkg::N_CELLS; i++) begin : g_root
		sfg_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (cvld[i]),
			.sq_i   (csq[i]),
			.vld_o  (cvld[i+1]),
			.sq_o   (csq[i+1])
		);
	end

	sfg_scale #(
		.FRAC_BITS (FRAC_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_i     (cvld[sfg_pkg::N_CELLS]),
		.len_i     (csq[sfg_pkg::N_CELLS].root),
		.pay_i     (csq[sfg_pkg::N_CELLS].pay),
		.mode      (spring_mode_q),
		.rest_len  (rest_length_q),
		.stiffness (spring_stiffness_q),
		.vld_o     (out_valid),
		.fx_o      (force_x),
		.fy_o      (force_y),
		.applied_o (force_applied),
		.sat_o     (saturated)
	);

`ifndef SYNTHESIS
	a_slack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !force_applied |-> force_x == '0 && force_y == '0 && !saturated)
		else $error("slack bungee beat carries force");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			force_x == sfg_pkg::POS_MAX || force_x == sfg_pkg::NEG_MIN ||
			force_y == sfg_pkg::POS_MAX || force_y == sfg_pkg::NEG_MIN)
		else $error("saturated flag without a clipped component");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(force_x) && $stable(force_y))
		else $error("result beat changed while stalled");
`endif

endmodule
